FILE: rtl/mrrs_pkg.sv
package mrrs_pkg;

  // Input item: a received frame byte or a holding register write
  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
  } req_t;

  // Result item: one reply byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } rsp_t;

  // Commands to the bit-serial CRC unit
  typedef struct packed {
    logic       init;
    logic       start;
    logic [7:0] data;
  } crc_ctrl_t;

  // CRC unit status
  typedef struct packed {
    logic        busy;
    logic [15:0] value;
  } crc_stat_t;

  localparam logic        KIND_FRAME_BYTE = 1'b0;
  localparam logic        KIND_REG_WRITE  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  FC_READ_HOLDING     = 8'h03;
  localparam logic [7:0]  EXC_FLAG            = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_ADDRESS = 8'h02;

  localparam logic [7:0]  MIN_FRAME_LEN = 8'd5;
  localparam int          HDR_LEN       = 6;
  localparam logic [7:0]  TALLY_MAX     = 8'd255;
  localparam logic [7:0]  CRC_LAG       = 8'd2;
  localparam logic [5:0]  MSG_HEAD_LEN  = 6'd3;

  // Configuration registers
  localparam int          CFG_IDX_W          = 1;
  localparam logic [0:0]  REG_SLAVE_ADDRESS  = 1'b0;
  localparam logic [0:0]  REG_MAX_READ_WORDS = 1'b1;
  localparam logic [7:0]  SLAVE_ADDRESS_RST  = 8'd8;
  localparam logic [3:0]  MAX_READ_WORDS_RST = 4'd8;

endpackage

FILE: rtl/mrrs_crc_serial.sv
module mrrs_crc_serial (
  input  logic                clk,
  input  logic                rst,
  input  mrrs_pkg::crc_ctrl_t ctrl,
  output mrrs_pkg::crc_stat_t stat
);

  localparam logic [2:0] LAST_BIT = 3'd7;

  logic [15:0] crc;
  logic [7:0]  sh;
  logic [2:0]  cnt;
  logic        busy;
  logic        fb;
  logic [15:0] crc_next;

  // one reflected CRC step per cycle, data LSB first
  always_comb begin
    fb       = crc[0] ^ sh[0];
    crc_next = {1'b0, crc[15:1]} ^ (fb ? mrrs_pkg::CRC_POLY : 16'h0000);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc  <= mrrs_pkg::CRC_INIT;
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.init) begin
      crc  <= mrrs_pkg::CRC_INIT;
      busy <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      crc <= crc_next;
      cnt <= cnt + 3'd1;
      if (cnt == LAST_BIT) begin
        busy <= 1'b0;
      end
    end
  end

  // data shifter, payload only
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sh <= ctrl.data;
    end else if (busy) begin
      sh <= {1'b0, sh[7:1]};
    end
  end

  assign stat.busy  = busy;
  assign stat.value = crc;

endmodule

FILE: rtl/mrrs_regfile.sv
module mrrs_regfile #(
  parameter int NUM_REGS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        wr_en,
  input  logic [2:0]                                  wr_index,
  input  logic [15:0]                                 wr_value,
  input  logic [$clog2((NUM_REGS > 1) ? NUM_REGS : 2)-1:0] rd_addr,
  output logic [15:0]                                 rd_data
);

  // only indices reachable by the 3-bit write index are stored; the rest read zero
  localparam int STORE = (NUM_REGS < 8) ? NUM_REGS : 8;
  localparam int SW    = (STORE > 1) ? $clog2(STORE) : 1;

  logic [15:0] regs [STORE];

  // write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE; i++) begin
        regs[i] <= '0;
      end
    end else if (wr_en && (int'(wr_index) < NUM_REGS)) begin
      regs[wr_index[SW-1:0]] <= wr_value;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (int'(rd_addr) < STORE) begin
      rd_data <= regs[rd_addr[SW-1:0]];
    end else begin
      rd_data <= '0;
    end
  end

endmodule

FILE: rtl/modbus_rtu_read_register_slave.sv
// Modbus RTU slave answering read-holding-registers (function 3).
// Input channel (req_valid / req_stall / req): each item is either a received
// frame byte (kind 0, frame_end marks the last byte) or a holding register
// write (kind 1). Output channel (rsp_valid / rsp_stall / rsp) carries reply
// bytes in transmit order, tx_last set on the final CRC byte.
// Config port (cfg_we / cfg_index / cfg_data): 0 = slave address,
// 1 = max read words; write only while idle.
// Sequencing: a register write is taken while idle. A frame byte is accepted,
// then the block waits for the bit-serial CRC unit, which works two bytes
// behind the input, so the first two bytes of a frame start no CRC step. At
// frame end a check state follows; then every reply payload byte passes
// register read, hand-off with CRC start and CRC shifting, and each of the
// two CRC bytes a fetch state and hand-off; a full 8-word reply runs through
// these steps per byte. The block takes one item at a time.
// Reset: clears the holding registers, the frame state and the output valid
// flag; configuration returns to address 8 and 8 words.
// A stalled reply byte holds in the output register; the next reply byte
// waits until it is taken, and new input is taken once the last reply byte
// sits in the output register.
module modbus_rtu_read_register_slave #(
  parameter int NUM_REGS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  mrrs_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output mrrs_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [mrrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int AW = $clog2((NUM_REGS > 1) ? NUM_REGS : 2);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RXCRC = 6'b000010,
    S_CHECK = 6'b000100,
    S_FETCH = 6'b001000,
    S_SEND  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state;

  logic [7:0]  slave_address;
  logic [3:0]  max_read_words;
  logic [7:0]  tally;
  logic [7:0]  held [2];
  logic [7:0]  hdr [mrrs_pkg::HDR_LEN];
  logic        end_pending;

  logic [7:0]  tx_id;
  logic [7:0]  tx_fc;
  logic [7:0]  tx_cnt;
  logic [6:0]  tx_start;
  logic [5:0]  tx_len;
  logic [5:0]  tx_idx;

  mrrs_pkg::crc_ctrl_t crc_ctrl;
  mrrs_pkg::crc_stat_t crc_st;

  logic        acc;
  logic        send_fire;
  logic        silent;
  logic        exc;
  logic [15:0] words;
  logic [15:0] start_addr;
  logic [16:0] span;
  logic [5:0]  idx_off;
  logic [7:0]  rd_sum;
  logic [15:0] rd_data;
  logic [7:0]  send_byte;
  logic        send_last;
  logic        send_msg;

  assign acc       = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign send_fire = (state == S_SEND) && (!rsp_valid || !rsp_stall);

  // frame check
  always_comb begin
    words      = {hdr[4], hdr[5]};
    start_addr = {hdr[2], hdr[3]};
    span       = {1'b0, start_addr} + {1'b0, words};
    silent     = (tally < mrrs_pkg::MIN_FRAME_LEN) || (hdr[0] != slave_address) ||
                 (crc_st.value != {held[1], held[0]}) ||
                 (hdr[1] != mrrs_pkg::FC_READ_HOLDING);
    exc        = (words > {12'd0, max_read_words}) || (span > 17'(NUM_REGS));
  end

  // register read address: word (idx - 3) / 2 of the requested range
  always_comb begin
    idx_off = tx_idx - mrrs_pkg::MSG_HEAD_LEN;
    rd_sum  = {1'b0, tx_start} + {3'd0, idx_off[5:1]};
  end

  // reply byte select
  always_comb begin
    send_msg  = (tx_idx < tx_len);
    send_last = 1'b0;
    if (send_msg) begin
      if (tx_idx == 6'd0) begin
        send_byte = tx_id;
      end else if (tx_idx == 6'd1) begin
        send_byte = tx_fc;
      end else if (tx_idx == 6'd2) begin
        send_byte = tx_cnt;
      end else if (tx_idx[0]) begin
        send_byte = rd_data[15:8];
      end else begin
        send_byte = rd_data[7:0];
      end
    end else if (tx_idx == tx_len) begin
      send_byte = crc_st.value[7:0];
    end else begin
      send_byte = crc_st.value[15:8];
      send_last = 1'b1;
    end
  end

  // CRC unit commands; the unit restarts for the reply and again after it
  always_comb begin
    crc_ctrl.init  = (state == S_CHECK) || (send_fire && send_last);
    crc_ctrl.start = ((state == S_IDLE) && acc && (req.kind == mrrs_pkg::KIND_FRAME_BYTE) &&
                      (tally >= mrrs_pkg::CRC_LAG)) || (send_fire && send_msg);
    crc_ctrl.data  = (state == S_IDLE) ? held[0] : send_byte;
  end

  mrrs_crc_serial u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctrl (crc_ctrl),
    .stat (crc_st)
  );

  mrrs_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (acc && (req.kind == mrrs_pkg::KIND_REG_WRITE)),
    .wr_index (req.reg_index),
    .wr_value (req.reg_value),
    .rd_addr  (rd_sum[AW-1:0]),
    .rd_data  (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= mrrs_pkg::SLAVE_ADDRESS_RST;
      max_read_words <= mrrs_pkg::MAX_READ_WORDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrrs_pkg::REG_SLAVE_ADDRESS:  slave_address  <= cfg_data;
        mrrs_pkg::REG_MAX_READ_WORDS: max_read_words <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tally       <= '0;
      held[0]     <= '0;
      held[1]     <= '0;
      for (int i = 0; i < mrrs_pkg::HDR_LEN; i++) begin
        hdr[i] <= '0;
      end
      end_pending <= 1'b0;
      tx_idx      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !send_fire) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && (req.kind == mrrs_pkg::KIND_FRAME_BYTE)) begin
            held[0] <= held[1];
            held[1] <= req.rx_byte;
            if (tally < 8'(mrrs_pkg::HDR_LEN)) begin
              hdr[tally[2:0]] <= req.rx_byte;
            end
            if (tally != mrrs_pkg::TALLY_MAX) begin
              tally <= tally + 8'd1;
            end
            end_pending <= req.frame_end;
            state       <= S_RXCRC;
          end
        end
        S_RXCRC: begin
          if (!crc_st.busy) begin
            state <= end_pending ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          tx_id    <= hdr[0];
          tx_start <= start_addr[6:0];
          tx_idx   <= '0;
          if (exc) begin
            tx_fc  <= hdr[1] | mrrs_pkg::EXC_FLAG;
            tx_cnt <= mrrs_pkg::EXC_ILLEGAL_ADDRESS;
            tx_len <= mrrs_pkg::MSG_HEAD_LEN;
          end else begin
            tx_fc  <= hdr[1];
            tx_cnt <= {3'd0, words[3:0], 1'b0};
            tx_len <= mrrs_pkg::MSG_HEAD_LEN + {1'b0, words[3:0], 1'b0};
          end
          // frame state back to reset values
          tally       <= '0;
          held[0]     <= '0;
          held[1]     <= '0;
          for (int i = 0; i < mrrs_pkg::HDR_LEN; i++) begin
            hdr[i] <= '0;
          end
          end_pending <= 1'b0;
          state       <= silent ? S_IDLE : S_FETCH;
        end
        S_FETCH: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (send_fire) begin
            rsp_valid <= 1'b1;
            if (send_msg) begin
              state <= S_WAIT;
            end else if (send_last) begin
              state <= S_IDLE;
            end else begin
              tx_idx <= tx_idx + 6'd1;
              state  <= S_FETCH;
            end
          end
        end
        S_WAIT: begin
          if (!crc_st.busy) begin
            tx_idx <= tx_idx + 6'd1;
            state  <= S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (send_fire) begin
      rsp.tx_byte <= send_byte;
      rsp.tx_last <= send_last;
    end
  end

  // a new CRC byte is never started while the unit is still shifting
  a_crc_no_overlap: assert property (@(posedge clk) disable iff (rst)
    crc_ctrl.start |-> !crc_st.busy)
    else $error("CRC start while busy");

  // input is only taken with the CRC unit at rest
  a_idle_crc_quiet: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !crc_st.busy)
    else $error("input ready while CRC busy");

  // reply index never runs past the two CRC bytes
  a_tx_idx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (tx_idx <= tx_len + 6'd1))
    else $error("reply index out of range");

  // the last reply byte hands control back to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (send_fire && send_last) |=> (state == S_IDLE) && rsp_valid && rsp.tx_last)
    else $error("last reply byte did not end the reply");

endmodule
